/* hdl/stc_pkg.sv */
// Shared types, codes and constants of the stepper travel controller.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package stc_pkg;

  localparam int unsigned StepW   = 16;
  localparam int unsigned CoilW   = 4;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned ModeW   = 3;

  localparam logic [StepW-1:0] TravelStepsRst = 16'd2048;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK   = 3'd0,
    REQ_OPEN   = 3'd1,
    REQ_CLOSE  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_MANUAL = 3'd4
  } req_e;

  typedef enum logic [ModeW-1:0] {
    MODE_CLOSED  = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_OPEN    = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [PhaseW-1:0]  phase;
    logic [CoilW-1:0]   coil;
    logic [StepW-1:0]   count;
    logic [StepW-1:0]   target;
    logic               rev;
    logic               run;
  } stc_state_t;

  typedef struct packed {
    logic [CoilW-1:0]  coil_pattern;
    logic [ModeW-1:0]  travel_state;
    logic              motor_running;
    logic              command_accepted;
    logic [StepW-1:0]  steps_taken;
    logic              target_reached;
  } stc_result_t;

  function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    unique case (phase)
      2'd0:    pat = 4'h1;
      2'd1:    pat = 4'h2;
      2'd2:    pat = 4'h4;
      default: pat = 4'h8;
    endcase
    return pat;
  endfunction

endpackage

/* hdl/stc_if.sv */
// Handshake channels of the stepper travel controller: request, result, config.
// Depends on stc_pkg for field widths.
`timescale 1ns / 1ps

interface stc_req_if;
  logic                       valid;
  logic                       ready;
  logic [stc_pkg::ReqW-1:0]   req_type;
  logic [stc_pkg::StepW-1:0]  run_steps;
  logic                       run_reverse;

  modport source (output valid, req_type, run_steps, run_reverse, input ready);
  modport sink   (input valid, req_type, run_steps, run_reverse, output ready);
endinterface

interface stc_res_if;
  logic                       valid;
  logic                       ready;
  logic [stc_pkg::CoilW-1:0]  coil_pattern;
  logic [stc_pkg::ModeW-1:0]  travel_state;
  logic                       motor_running;
  logic                       command_accepted;
  logic [stc_pkg::StepW-1:0]  steps_taken;
  logic                       target_reached;

  modport source (output valid, coil_pattern, travel_state, motor_running,
                  command_accepted, steps_taken, target_reached, input ready);
  modport sink   (input valid, coil_pattern, travel_state, motor_running,
                  command_accepted, steps_taken, target_reached, output ready);
endinterface

interface stc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [stc_pkg::StepW-1:0]  travel_steps;

  modport source (output valid, travel_steps, input ready);
  modport sink   (input valid, travel_steps, output ready);
endinterface

/* hdl/stc_step.sv */
// Next-state and result logic for one request item of the travel controller.
// Purely combinational; depends on stc_pkg.
`timescale 1ns / 1ps

module stc_step (
  input  stc_pkg::stc_state_t            state_i,
  input  logic [stc_pkg::ReqW-1:0]       req_type_i,
  input  logic [stc_pkg::StepW-1:0]      run_steps_i,
  input  logic                           run_reverse_i,
  input  logic [stc_pkg::StepW-1:0]      travel_steps_i,
  output stc_pkg::stc_state_t            state_o,
  output stc_pkg::stc_result_t           result_o
);

  always_comb begin
    stc_pkg::stc_state_t nxt;
    logic                acc;
    logic                reached;
    nxt     = state_i;
    acc     = 1'b0;
    reached = 1'b0;
    unique case (stc_pkg::req_e'(req_type_i))
      stc_pkg::REQ_TICK: begin
        if (state_i.run) begin
          nxt.phase = state_i.rev ? state_i.phase - 2'd1 : state_i.phase + 2'd1;
          nxt.coil  = stc_pkg::coil_of(nxt.phase);
          if (state_i.target != '0) begin
            nxt.count = state_i.count + 16'd1;
            if (nxt.count >= state_i.target) begin
              nxt.coil = '0;
              nxt.run  = 1'b0;
              nxt.mode = state_i.rev ? stc_pkg::MODE_CLOSED : stc_pkg::MODE_OPEN;
              reached  = 1'b1;
            end
          end
        end
      end
      stc_pkg::REQ_OPEN: begin
        if (state_i.mode == stc_pkg::MODE_CLOSED ||
            state_i.mode == stc_pkg::MODE_STOPPED) begin
          nxt.mode   = stc_pkg::MODE_OPENING;
          nxt.rev    = 1'b0;
          nxt.count  = '0;
          nxt.target = travel_steps_i;
          nxt.run    = 1'b1;
          acc        = 1'b1;
        end
      end
      stc_pkg::REQ_CLOSE: begin
        if (state_i.mode == stc_pkg::MODE_OPEN ||
            state_i.mode == stc_pkg::MODE_STOPPED) begin
          nxt.mode   = stc_pkg::MODE_CLOSING;
          nxt.rev    = 1'b1;
          nxt.count  = '0;
          nxt.target = travel_steps_i;
          nxt.run    = 1'b1;
          acc        = 1'b1;
        end
      end
      stc_pkg::REQ_STOP: begin
        nxt.coil = '0;
        nxt.run  = 1'b0;
        if (state_i.mode == stc_pkg::MODE_OPENING ||
            state_i.mode == stc_pkg::MODE_CLOSING) begin
          nxt.mode = stc_pkg::MODE_STOPPED;
        end
      end
      stc_pkg::REQ_MANUAL: begin
        nxt.coil   = '0;
        nxt.mode   = stc_pkg::MODE_OPENING;
        nxt.rev    = run_reverse_i;
        nxt.count  = '0;
        nxt.target = run_steps_i;
        nxt.run    = 1'b1;
      end
      default: begin
      end
    endcase
    state_o                   = nxt;
    result_o.coil_pattern     = nxt.coil;
    result_o.travel_state     = nxt.mode;
    result_o.motor_running    = nxt.run;
    result_o.command_accepted = acc;
    result_o.steps_taken      = nxt.count;
    result_o.target_reached   = reached;
  end

endmodule

/* hdl/stepper_travel_controller_core.sv */
// Top level of the stepper travel controller: input register, step logic, result register.
// Depends on stc_pkg, the channel interfaces in stc_if.sv and stc_step.
//
//   channel  dir  payload                                         accepted when
//   req_i    in   req_type, run_steps, run_reverse                valid && ready
//   res_o    out  coil, state, running, accepted, steps, reached  valid && ready
//   cfg_i    in   travel_steps                                    valid && ready
//
// One item per cycle unless res_o stalls; each result passes through the result register.
// Latency is set by the input register and the result register around stc_step.
// Reset clears state to closed, coils off, travel_steps to 2048.
// A stalled result holds in the result register while one more item waits in the
// input register; req_i.ready falls only when both are full. cfg_i is always ready.
`timescale 1ns / 1ps

module stepper_travel_controller_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  stc_req_if.sink          req_i,
  stc_res_if.source        res_o,
  stc_cfg_if.sink          cfg_i
);

  logic                           in_vld_q;
  logic [stc_pkg::ReqW-1:0]       req_type_q;
  logic [stc_pkg::StepW-1:0]      run_steps_q;
  logic                           run_reverse_q;
  logic                           out_vld_q;
  stc_pkg::stc_result_t           res_q;
  stc_pkg::stc_result_t           res_d;
  stc_pkg::stc_state_t            state_q;
  stc_pkg::stc_state_t            state_d;
  logic [stc_pkg::StepW-1:0]      travel_steps_q;
  logic                           out_free;
  logic                           adv;

  assign out_free    = !out_vld_q || res_o.ready;
  assign adv         = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;
  assign cfg_i.ready = 1'b1;

  stc_step u_step (
    .state_i        (state_q),
    .req_type_i     (req_type_q),
    .run_steps_i    (run_steps_q),
    .run_reverse_i  (run_reverse_q),
    .travel_steps_i (travel_steps_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      travel_steps_q <= stc_pkg::TravelStepsRst;
      state_q        <= '{mode: stc_pkg::MODE_CLOSED, default: '0};
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (adv) begin
        state_q <= state_d;
      end
      if (cfg_i.valid) begin
        travel_steps_q <= cfg_i.travel_steps;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_type_q    <= req_i.req_type;
      run_steps_q   <= req_i.run_steps;
      run_reverse_q <= req_i.run_reverse;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.coil_pattern     = res_q.coil_pattern;
  assign res_o.travel_state     = res_q.travel_state;
  assign res_o.motor_running    = res_q.motor_running;
  assign res_o.command_accepted = res_q.command_accepted;
  assign res_o.steps_taken      = res_q.steps_taken;
  assign res_o.target_reached   = res_q.target_reached;

`ifndef SYNTHESIS
  a_coil_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(state_q.coil))
    else $error("coil drive not one-hot");

  a_idle_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.run |-> state_q.coil == '0)
    else $error("coils driven while motor idle");

  a_reached_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.target_reached |->
      !res_q.motor_running && res_q.coil_pattern == '0)
    else $error("target reached but motor still driven");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without an item");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for stepper_travel_controller_core: directed and random ticks
// and commands, checked item by item against an in-bench predictor of the sequencer.
// Depends on stc_pkg, the channel interfaces in stc_if.sv and the core itself.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [stc_pkg::ReqW-1:0]  kind;
    logic [stc_pkg::StepW-1:0] steps;
    logic                      rev;
  } cmd_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseItems = 200;

  logic clk_i;
  logic rst_ni;

  stc_req_if req_ch ();
  stc_res_if res_ch ();
  stc_cfg_if cfg_ch ();

  stepper_travel_controller_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  cmd_t                 cmd_q[$];
  stc_pkg::stc_result_t travel_exp_q[$];

  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned errors;
  int unsigned cycles;
  int unsigned cfg_writes;
  logic        req_taken;

  logic [stc_pkg::StepW-1:0]  m_travel;
  stc_pkg::mode_e             m_mode;
  logic [stc_pkg::PhaseW-1:0] m_phase;
  logic [stc_pkg::CoilW-1:0]  m_coil;
  logic [stc_pkg::StepW-1:0]  m_count;
  logic [stc_pkg::StepW-1:0]  m_target;
  logic                       m_rev;
  logic                       m_run;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic begin_run(input stc_pkg::mode_e mode, input logic rev,
                           input logic [stc_pkg::StepW-1:0] target);
    m_mode   = mode;
    m_rev    = rev;
    m_count  = '0;
    m_target = target;
    m_run    = 1'b1;
  endtask

  task automatic predict_travel(input cmd_t c);
    stc_pkg::stc_result_t r;
    logic                 took;
    logic                 hit;
    took = 1'b0;
    hit  = 1'b0;
    case (c.kind)
      stc_pkg::REQ_TICK: begin
        if (m_run) begin
          m_phase = m_rev ? m_phase - 2'd1 : m_phase + 2'd1;
          m_coil  = 4'b0001 << m_phase;
          if (m_target != '0) begin
            m_count = m_count + 16'd1;
            if (m_count >= m_target) begin
              m_coil = '0;
              m_run  = 1'b0;
              m_mode = m_rev ? stc_pkg::MODE_CLOSED : stc_pkg::MODE_OPEN;
              hit    = 1'b1;
            end
          end
        end
      end
      stc_pkg::REQ_OPEN: begin
        if (m_mode == stc_pkg::MODE_CLOSED || m_mode == stc_pkg::MODE_STOPPED) begin
          begin_run(stc_pkg::MODE_OPENING, 1'b0, m_travel);
          took = 1'b1;
        end
      end
      stc_pkg::REQ_CLOSE: begin
        if (m_mode == stc_pkg::MODE_OPEN || m_mode == stc_pkg::MODE_STOPPED) begin
          begin_run(stc_pkg::MODE_CLOSING, 1'b1, m_travel);
          took = 1'b1;
        end
      end
      stc_pkg::REQ_STOP: begin
        m_coil = '0;
        m_run  = 1'b0;
        if (m_mode == stc_pkg::MODE_OPENING || m_mode == stc_pkg::MODE_CLOSING) begin
          m_mode = stc_pkg::MODE_STOPPED;
        end
      end
      stc_pkg::REQ_MANUAL: begin
        m_coil = '0;
        begin_run(stc_pkg::MODE_OPENING, c.rev, c.steps);
      end
      default: ;
    endcase
    r.coil_pattern     = m_coil;
    r.travel_state     = m_mode;
    r.motor_running    = m_run;
    r.command_accepted = took;
    r.steps_taken      = m_count;
    r.target_reached   = hit;
    travel_exp_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [stc_pkg::StepW-1:0] want,
                             input logic [stc_pkg::StepW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    stc_pkg::stc_result_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end else if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        m_travel = cfg_ch.travel_steps;
        cfg_writes++;
      end
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        predict_travel(cmd_q.pop_front());
      end
      if (res_ch.valid && res_ch.ready) begin
        if (travel_exp_q.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = travel_exp_q.pop_front();
          check_field("coil_pattern", want.coil_pattern, res_ch.coil_pattern);
          check_field("travel_state", want.travel_state, res_ch.travel_state);
          check_field("motor_running", want.motor_running, res_ch.motor_running);
          check_field("command_accepted", want.command_accepted, res_ch.command_accepted);
          check_field("steps_taken", want.steps_taken, res_ch.steps_taken);
          check_field("target_reached", want.target_reached, res_ch.target_reached);
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    if (!req_ch.valid || req_taken) begin
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= cmd_q[0].kind;
        req_ch.run_steps   <= cmd_q[0].steps;
        req_ch.run_reverse <= cmd_q[0].rev;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic cmd_t make_cmd(input logic [stc_pkg::ReqW-1:0] kind,
                                    input logic [stc_pkg::StepW-1:0] steps,
                                    input logic rev);
    cmd_t c;
    c.kind  = kind;
    c.steps = steps;
    c.rev   = rev;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    int unsigned sel;
    pick    = $urandom_range(99);
    sel     = $urandom_range(99);
    c.steps = 16'($urandom);
    c.rev   = 1'($urandom);
    if (pick < 64) c.kind = stc_pkg::REQ_TICK;
    else if (pick < 72) c.kind = stc_pkg::REQ_OPEN;
    else if (pick < 80) c.kind = stc_pkg::REQ_CLOSE;
    else if (pick < 85) c.kind = stc_pkg::REQ_STOP;
    else if (pick < 97) begin
      c.kind = stc_pkg::REQ_MANUAL;
      if (sel < 55) c.steps = 16'($urandom_range(1, 12));
      else if (sel < 70) c.steps = '0;
      else if (sel < 80) c.steps = 16'hFFFF;
    end else begin
      c.kind = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() != 0 || travel_exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_travel_steps(input logic [stc_pkg::StepW-1:0] value);
    int unsigned seen;
    seen = cfg_writes;
    cfg_ch.valid        <= 1'b1;
    cfg_ch.travel_steps <= value;
    @(negedge clk_i);
    while (cfg_writes == seen) @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle  = 0;
        recv_stall = 0;
      end
      1: begin
        send_idle  = 80;
        recv_stall = 0;
      end
      2: begin
        send_idle  = 0;
        recv_stall = 80;
      end
      default: begin
        send_idle  = 20;
        recv_stall = 20;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [stc_pkg::StepW-1:0] travel_set[8];
    travel_set = '{16'd1, 16'hFFFF, 16'd0, 16'd4, 16'd3, 16'd2048, 16'd7, 16'd2};
    travel_set[6] = 16'($urandom_range(2, 20));
    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = stc_pkg::REQ_TICK;
    req_ch.run_steps    = '0;
    req_ch.run_reverse  = 1'b0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.travel_steps = '0;
    req_taken           = 1'b0;
    errors              = 0;
    cycles              = 0;
    cfg_writes          = 0;
    send_idle           = 0;
    recv_stall          = 0;
    m_travel            = stc_pkg::TravelStepsRst;
    m_mode              = stc_pkg::MODE_CLOSED;
    m_phase             = '0;
    m_coil              = '0;
    m_count             = '0;
    m_target            = '0;
    m_rev               = 1'b0;
    m_run               = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset travel length: open and stop from closed
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_CLOSE, 16'hFFFF, 1'b1));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_OPEN, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_STOP, 16'h0000, 1'b0));
    wait_idle();
    write_travel_steps(16'd2);
    cmd_q.push_back(make_cmd(stc_pkg::REQ_CLOSE, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_OPEN, 16'hFFFF, 1'b1));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_CLOSE, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_OPEN, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_MANUAL, 16'h0000, 1'b1));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_MANUAL, 16'hFFFF, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_MANUAL, 16'h0001, 1'b1));
    cmd_q.push_back(make_cmd(stc_pkg::REQ_TICK, 16'h0000, 1'b0));
    cmd_q.push_back(make_cmd(3'd5, 16'hFFFF, 1'b1));
    cmd_q.push_back(make_cmd(3'd6, 16'h5555, 1'b0));
    cmd_q.push_back(make_cmd(3'd7, 16'hAAAA, 1'b1));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      set_idling(p % 4);
      write_travel_steps(travel_set[p]);
      for (int i = 0; i < PhaseItems; i++) cmd_q.push_back(random_cmd());
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    if (errors == 0 && travel_exp_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
